// File: rtl/core/b2da_pkg.sv
// b2da_pkg: shared constants and helpers for the binary to decimal ascii unit
// no dependencies; imported by every module in rtl/core
package b2da_pkg;

	localparam int CHAR_W     = 8;
	localparam int NUM_STAGES = 4;
	localparam int MAX_BITS   = 32;

	localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_NEWLINE = 8'h0A;

	// decimal digits needed for an unsigned number of the given width
	// floor(bits * log10(2)) + 1, with log10(2) taken as 1233 / 4096
	function automatic int digits_for(input int bits);
		return ((bits * 1233) >> 12) + 1;
	endfunction

endpackage

// File: rtl/core/b2da_stage.sv
// b2da_stage: one register stage of the double-dabble pipeline
// runs STEPS add-3 and shift steps per beat; uses b2da_pkg
module b2da_stage
	import b2da_pkg::*;
#(
	parameter int PAD_BITS = 32,
	parameter int BCD_BITS = 40,
	parameter int STEPS    = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [PAD_BITS-1:0] in_bin,
	input  logic [BCD_BITS-1:0] in_bcd,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [PAD_BITS-1:0] out_bin,
	output logic [BCD_BITS-1:0] out_bcd
);

	localparam int NUM_DIGITS = BCD_BITS / 4;

	logic                valid_s1;
	logic [PAD_BITS-1:0] bin_s1;
	logic [BCD_BITS-1:0] bcd_s1;
	logic [PAD_BITS-1:0] bin_w;
	logic [BCD_BITS-1:0] bcd_w;

	// add 3 to every digit of five or more, then shift one bit in
	always_comb begin
		bin_w = in_bin;
		bcd_w = in_bcd;
		for (int s = 0; s < STEPS; s++) begin
			for (int k = 0; k < NUM_DIGITS; k++) begin
				if (bcd_w[4*k +: 4] >= 4'd5) begin
					bcd_w[4*k +: 4] = bcd_w[4*k +: 4] + 4'd3;
				end
			end
			bcd_w = {bcd_w[BCD_BITS-2:0], bin_w[PAD_BITS-1]};
			bin_w = {bin_w[PAD_BITS-2:0], 1'b0};
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bin_s1 <= bin_w;
			bcd_s1 <= bcd_w;
		end
	end

	assign out_valid = valid_s1;
	assign out_bin   = bin_s1;
	assign out_bcd   = bcd_s1;

endmodule

// File: rtl/core/b2da_emit.sv
// b2da_emit: serializes a packed bcd number into ascii beats
// suppresses leading zeros, appends newline with last; uses b2da_pkg
module b2da_emit
	import b2da_pkg::*;
#(
	parameter int NUM_DIGITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [4*NUM_DIGITS-1:0] in_bcd,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CHAR_W-1:0]     out_char,
	output logic                  out_last
);

	localparam int DIG_W = $clog2(NUM_DIGITS);

	logic                    busy_q;
	logic                    nl_q;
	logic [DIG_W-1:0]        pos_q;
	logic [4*NUM_DIGITS-1:0] bcd_q;
	logic                    out_valid_q;
	logic [CHAR_W-1:0]       out_char_q;
	logic                    out_last_q;
	logic [DIG_W-1:0]        lead;
	logic [3:0]              cur;
	logic                    out_free;

	// highest nonzero digit, or digit 0 for a zero value
	always_comb begin
		lead = '0;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			if (in_bcd[4*k +: 4] != 4'd0) begin
				lead = DIG_W'(k);
			end
		end
	end

	assign cur      = bcd_q[4*pos_q +: 4];
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !busy_q) begin
				busy_q <= 1'b1;
			end else if (busy_q && out_free && nl_q) begin
				busy_q <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !busy_q) begin
			bcd_q <= in_bcd;
			pos_q <= lead;
			nl_q  <= 1'b0;
		end else if (busy_q && out_free && !nl_q) begin
			if (pos_q == '0) begin
				nl_q <= 1'b1;
			end else begin
				pos_q <= pos_q - 1'b1;
			end
		end
		if (busy_q && out_free) begin
			if (nl_q) begin
				out_char_q <= ASCII_NEWLINE;
				out_last_q <= 1'b1;
			end else begin
				out_char_q <= ASCII_ZERO + {4'd0, cur};
				out_last_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

// File: rtl/core/binary_to_decimal_ascii_unit.sv
// binary_to_decimal_ascii_unit: top level, unsigned binary to decimal ascii text
// instantiates b2da_stage and b2da_emit; uses b2da_pkg
//
// usage
//   slave channel s_*: one beat carries one unsigned number in s_tdata
//   master channel m_*: one beat per character, most significant digit first,
//   leading zeros suppressed (zero gives a single '0'), then a newline beat
//   with m_tlast high that closes the number's run
//   conversion is a four-stage double-dabble pipeline, each stage running
//   a quarter of the shift and add-3 steps, followed by a serializer
//   an input beat passes the stage registers, then the serializer's bcd
//   and output registers; the serializer takes a new number only once
//   the newline of the last is registered, so it sets the rate and the
//   pipeline ahead of it holds up to four more numbers meanwhile
//   reset: arst_n clears all valid bits, the serializer is idle after reset
//   stalls: with m_tready low the output beat holds, the serializer waits,
//   the pipeline fills and then s_tready drops; nothing is lost or repeated
module binary_to_decimal_ascii_unit
	import b2da_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // [31:0] value
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [CHAR_W-1:0] m_tdata,   // [7:0] character
	output logic              m_tlast
);

	// the value field is 32 bits wide, wider settings convert all of it
	localparam int CONV_BITS  = (VALUE_BITS < MAX_BITS) ? VALUE_BITS : MAX_BITS;
	localparam int STEPS      = (CONV_BITS + NUM_STAGES - 1) / NUM_STAGES;
	localparam int PAD_BITS   = STEPS * NUM_STAGES;
	localparam int NUM_DIGITS = digits_for(CONV_BITS);
	localparam int BCD_BITS   = 4 * NUM_DIGITS;

	// stage boundaries: index 0 is the input, NUM_STAGES the serializer input
	logic [PAD_BITS-1:0] bin_w [NUM_STAGES+1];
	logic [BCD_BITS-1:0] bcd_w [NUM_STAGES+1];
	logic                vld_w [NUM_STAGES+1];
	logic                rdy_w [NUM_STAGES+1];

	// bits above the conversion width are dropped, padding shifts in as zeros
	assign bin_w[0]  = PAD_BITS'(s_tdata[CONV_BITS-1:0]);
	assign bcd_w[0]  = '0;
	assign vld_w[0]  = s_tvalid;
	assign s_tready  = rdy_w[0];

	for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
		b2da_stage #(
			.PAD_BITS (PAD_BITS),
			.BCD_BITS (BCD_BITS),
			.STEPS    (STEPS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_w[g]),
			.in_ready  (rdy_w[g]),
			.in_bin    (bin_w[g]),
			.in_bcd    (bcd_w[g]),
			.out_valid (vld_w[g+1]),
			.out_ready (rdy_w[g+1]),
			.out_bin   (bin_w[g+1]),
			.out_bcd   (bcd_w[g+1])
		);
	end

	// serializer: registered, one char per cycle in a number unless stalled
	b2da_emit #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_w[NUM_STAGES]),
		.in_ready  (rdy_w[NUM_STAGES]),
		.in_bcd    (bcd_w[NUM_STAGES]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

// File: tb/binary_to_decimal_ascii_checker.sv
`timescale 1ns / 100ps
// binary_to_decimal_ascii_checker: watches both stream channels of the unit,
// predicts the decimal text of every accepted number and compares each output beat
// depends on b2da_pkg for the character width and the ascii codes
module binary_to_decimal_ascii_checker
	import b2da_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [31:0]       s_tdata,   // [31:0] value
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [CHAR_W-1:0] m_tdata,   // [7:0] character
	input  logic              m_tlast,
	output int                mismatch_count,
	output int                chars_pending
);

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_beat_t;

	text_beat_t expected_text[$];
	int         errors;
	int         chars_seen;

	assign mismatch_count = errors;
	assign chars_pending  = expected_text.size();

	// decimal digits of the masked value, most significant first, then the newline
	function automatic void push_decimal_text(input logic [31:0] value);
		logic [CHAR_W-1:0] digit_chars[20];
		logic [63:0]       rest;
		logic [63:0]       mask;
		int                count;
		text_beat_t        beat;
		mask  = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
		rest  = 64'(value) & mask;
		count = 0;
		do begin
			digit_chars[count] = ASCII_ZERO + CHAR_W'(rest % 64'd10);
			rest  = rest / 64'd10;
			count++;
		end while (rest != 0 && count < 20);
		for (int i = count - 1; i >= 0; i--) begin
			beat.character = digit_chars[i];
			beat.last      = 1'b0;
			expected_text.push_back(beat);
		end
		beat.character = ASCII_NEWLINE;
		beat.last      = 1'b1;
		expected_text.push_back(beat);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		text_beat_t want;
		if (!arst_n) begin
			expected_text.delete();
			errors     = 0;
			chars_seen = 0;
		end else begin
			if (s_tvalid && s_tready)
				push_decimal_text(s_tdata);
			if (m_tvalid && m_tready) begin
				chars_seen++;
				if (expected_text.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected char beat %0d: char=%02h last=%b",
							chars_seen, m_tdata, m_tlast);
				end else begin
					want = expected_text.pop_front();
					if (m_tdata !== want.character || m_tlast !== want.last) begin
						errors++;
						if (errors <= 10)
							$display("char beat %0d: expected char=%02h last=%b, got char=%02h last=%b",
								chars_seen, want.character, want.last, m_tdata, m_tlast);
					end
				end
			end
		end
	end

endmodule

// File: tb/binary_to_decimal_ascii_unit_test.sv
`timescale 1ns / 100ps
// binary_to_decimal_ascii_unit_test: stimulus and verdict for the binary to decimal unit
// instantiates binary_to_decimal_ascii_unit and binary_to_decimal_ascii_checker
module binary_to_decimal_ascii_unit_test;
	import b2da_pkg::*;

	// cycles without any beat on either channel before the run is declared hung
	localparam int HANG_LIMIT = 2000;
	// quiet cycles after the last character, well over the pipeline latency
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_PER_PHASE = 26;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [31:0]       s_tdata;   // [31:0] value
	logic              m_tvalid;
	logic              m_tready;
	logic [CHAR_W-1:0] m_tdata;   // [7:0] character
	logic              m_tlast;

	int mismatch_count;
	int chars_pending;
	int send_idle_pct;
	int ready_idle_pct;
	int quiet_cycles = 0;

	binary_to_decimal_ascii_unit #(
		.VALUE_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	binary_to_decimal_ascii_checker #(
		.VALUE_BITS(32)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.mismatch_count(mismatch_count),
		.chars_pending(chars_pending)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: ready decided afresh at every falling edge
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= ready_idle_pct);
		end
	end

	// hang detection: count cycles in which no beat moves on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("binary_to_decimal_ascii_unit_test: FAIL");
			$finish;
		end
	end

	// one number beat: random idle cycles first, then hold valid until accepted
	task automatic send_number(input logic [31:0] number);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= number;
		do @(posedge clk); while (!s_tready);
	endtask

	// random number with a random bit length, so every digit count shows up
	task automatic send_random_number();
		logic [31:0] number;
		int          bits;
		number = $urandom;
		case ($urandom_range(3))
			0: number = number;                        // full width
			1: number = number >> $urandom_range(31);  // any length
			2: number = number % 1000;                 // short runs
			default: begin
				bits = $urandom_range(31);
				// at or just below a power of two
				number = (32'd1 << bits) - 32'($urandom_range(2));
			end
		endcase
		send_number(number);
	endtask

	task automatic release_input();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	initial begin
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		arst_n         = 1'b0;
		send_idle_pct  = 22;
		ready_idle_pct = 62;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: zero, single digits, digit count boundaries, full range
		send_number(32'd0);
		send_number(32'd1);
		send_number(32'd9);
		send_number(32'd10);
		send_number(32'd99);
		send_number(32'd100);
		send_number(32'd101);
		send_number(32'd999999);
		send_number(32'd1000000);
		send_number(32'd999999999);
		send_number(32'd1000000000);
		send_number(32'd4000000000);
		send_number(32'hFFFF_FFFF);
		send_number(32'hFFFF_FFFE);
		send_number(32'h8000_0000);
		send_number(32'h7FFF_FFFF);
		send_number(32'h5555_5555);
		send_number(32'hAAAA_AAAA);
		send_number(32'd1234567890);
		send_number(32'd0);
		send_number(32'd0);
		send_number(32'd7);

		// phase one: sender mostly busy, receiver often stalls
		repeat (RANDOM_PER_PHASE) send_random_number();

		// phase two: roles swapped
		send_idle_pct  = 62;
		ready_idle_pct = 22;
		repeat (RANDOM_PER_PHASE) send_random_number();

		// phase three: back to back on both sides
		send_idle_pct  = 0;
		ready_idle_pct = 0;
		repeat (RANDOM_PER_PHASE) send_random_number();
		release_input();

		// drain: every predicted character must come out
		while (chars_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("binary_to_decimal_ascii_unit_test: PASS");
		else
			$display("binary_to_decimal_ascii_unit_test: FAIL");
		$finish;
	end

endmodule
